// File: design/eupt_pkg.sv
// ----------------------------------------------------------------------------
// eupt_pkg
// Shared constants, types and helpers for the Euler pose to transform block.
// ----------------------------------------------------------------------------
package eupt_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int ROT_FRAC_BITS = 14;
  localparam int ROT_W         = ROT_FRAC_BITS + 2;
  localparam int POS_W         = 32;

  localparam int CORDIC_STEPS = 30;
  localparam int CW           = 34;                 // CORDIC datapath width
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;   // fold + steps + finish

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q30     = 34'sd1073741824;

  typedef logic signed [31:0]      q30_t;
  typedef logic signed [63:0]      q60_t;
  typedef logic signed [ROT_W-1:0] rot_t;
  typedef logic signed [POS_W-1:0] pos_t;

  typedef logic [31:0] atan_tab_t [0:CORDIC_STEPS-1];
  localparam atan_tab_t ATAN_TAB = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // Q60 to output format, round half up, clamp to +/- one.
  function automatic rot_t round_q60(input q60_t v);
    q60_t r;
    r = (v + (q60_t'(1) <<< (60 - ROT_FRAC_BITS - 1))) >>> (60 - ROT_FRAC_BITS);
    if (r > (q60_t'(1) <<< ROT_FRAC_BITS)) begin
      r = q60_t'(1) <<< ROT_FRAC_BITS;
    end else if (r < -(q60_t'(1) <<< ROT_FRAC_BITS)) begin
      r = -(q60_t'(1) <<< ROT_FRAC_BITS);
    end
    return r[ROT_W-1:0];
  endfunction

endpackage

// File: design/eupt_cordic.sv
// ----------------------------------------------------------------------------
// eupt_cordic
// Pipelined rotation-mode CORDIC: binary angle to Q30 cosine and sine.
// ----------------------------------------------------------------------------
module eupt_cordic (
  input  logic                                 clk,
  input  logic signed [eupt_pkg::ANGLE_BITS-1:0] angle_i,
  output eupt_pkg::q30_t                       cos_o,
  output eupt_pkg::q30_t                       sin_o
);
  import eupt_pkg::*;

  logic signed [CW-1:0] x_r [0:CORDIC_STEPS];
  logic signed [CW-1:0] y_r [0:CORDIC_STEPS];
  logic signed [CW-1:0] z_r [0:CORDIC_STEPS];
  logic                 neg_r [0:CORDIC_STEPS];
  logic [31:0]          a_nxt;
  logic                 neg_nxt;
  logic signed [CW-1:0] xc_nxt;
  logic signed [CW-1:0] yc_nxt;
  q30_t                 cos_r;
  q30_t                 sin_r;

  // quadrant fold: second and third quadrants rotate by pi
  always_comb begin
    a_nxt   = {angle_i, {(32-ANGLE_BITS){1'b0}}};
    neg_nxt = a_nxt[31] ^ a_nxt[30];
    if (neg_nxt) begin
      a_nxt[31] = ~a_nxt[31];
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]   <= CORDIC_GAIN;
    y_r[0]   <= '0;
    z_r[0]   <= CW'(signed'(a_nxt));
    neg_r[0] <= neg_nxt;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (!z_r[i][CW-1]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - CW'(ATAN_TAB[i]);
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + CW'(ATAN_TAB[i]);
      end
      neg_r[i+1] <= neg_r[i];
    end
  end

  always_comb begin
    xc_nxt = x_r[CORDIC_STEPS];
    yc_nxt = y_r[CORDIC_STEPS];
    if (xc_nxt > ONE_Q30) xc_nxt = ONE_Q30;
    else if (xc_nxt < -ONE_Q30) xc_nxt = -ONE_Q30;
    if (yc_nxt > ONE_Q30) yc_nxt = ONE_Q30;
    else if (yc_nxt < -ONE_Q30) yc_nxt = -ONE_Q30;
    if (neg_r[CORDIC_STEPS]) begin
      xc_nxt = -xc_nxt;
      yc_nxt = -yc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cos_r <= xc_nxt[31:0];
    sin_r <= yc_nxt[31:0];
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

// File: design/eupt_matrix.sv
// ----------------------------------------------------------------------------
// eupt_matrix
// Three-stage product, sum and rounding datapath for the rotation entries.
// ----------------------------------------------------------------------------
module eupt_matrix (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  input  eupt_pkg::q30_t       cr_i,
  input  eupt_pkg::q30_t       sr_i,
  input  eupt_pkg::q30_t       cp_i,
  input  eupt_pkg::q30_t       sp_i,
  input  eupt_pkg::q30_t       cy_i,
  input  eupt_pkg::q30_t       sy_i,
  input  eupt_pkg::pos_t       tx_i,
  input  eupt_pkg::pos_t       ty_i,
  input  eupt_pkg::pos_t       tz_i,
  output logic                 valid_o,
  output eupt_pkg::rot_t       rot_o [0:8],
  output eupt_pkg::pos_t       tx_o,
  output eupt_pkg::pos_t       ty_o,
  output eupt_pkg::pos_t       tz_o
);
  import eupt_pkg::*;

  // stage 1
  logic  v1_r, v2_r, v3_r;
  q30_t  cysp_r, sysp_r, sp1_r, sr1_r, cr1_r;
  q60_t  cycp_r, sycr_r, sysr_r, sycp_r, cycr_r, cysr_r, cpsr_r, cpcr_r;
  q60_t  cysp_nxt, sysp_nxt;
  pos_t  tx1_r, ty1_r, tz1_r, tx2_r, ty2_r, tz2_r, tx3_r, ty3_r, tz3_r;
  // stage 2
  q60_t  a01_r, a02_r, a11_r, a12_r;
  q60_t  cycp2_r, sycr2_r, sysr2_r, sycp2_r, cycr2_r, cysr2_r, cpsr2_r, cpcr2_r;
  q30_t  sp2_r;
  // stage 3
  rot_t  rot_r [0:8];

  always_comb begin
    cysp_nxt = (q60_t'(cy_i) * q60_t'(sp_i) + (q60_t'(1) <<< 29)) >>> 30;
    sysp_nxt = (q60_t'(sy_i) * q60_t'(sp_i) + (q60_t'(1) <<< 29)) >>> 30;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    cysp_r <= cysp_nxt[31:0];
    sysp_r <= sysp_nxt[31:0];
    sp1_r  <= sp_i;
    sr1_r  <= sr_i;
    cr1_r  <= cr_i;
    cycp_r <= q60_t'(cy_i) * q60_t'(cp_i);
    sycr_r <= q60_t'(sy_i) * q60_t'(cr_i);
    sysr_r <= q60_t'(sy_i) * q60_t'(sr_i);
    sycp_r <= q60_t'(sy_i) * q60_t'(cp_i);
    cycr_r <= q60_t'(cy_i) * q60_t'(cr_i);
    cysr_r <= q60_t'(cy_i) * q60_t'(sr_i);
    cpsr_r <= q60_t'(cp_i) * q60_t'(sr_i);
    cpcr_r <= q60_t'(cp_i) * q60_t'(cr_i);
    tx1_r  <= tx_i;
    ty1_r  <= ty_i;
    tz1_r  <= tz_i;

    a01_r   <= q60_t'(cysp_r) * q60_t'(sr1_r);
    a02_r   <= q60_t'(cysp_r) * q60_t'(cr1_r);
    a11_r   <= q60_t'(sysp_r) * q60_t'(sr1_r);
    a12_r   <= q60_t'(sysp_r) * q60_t'(cr1_r);
    cycp2_r <= cycp_r;
    sycr2_r <= sycr_r;
    sysr2_r <= sysr_r;
    sycp2_r <= sycp_r;
    cycr2_r <= cycr_r;
    cysr2_r <= cysr_r;
    cpsr2_r <= cpsr_r;
    cpcr2_r <= cpcr_r;
    sp2_r   <= sp1_r;
    tx2_r   <= tx1_r;
    ty2_r   <= ty1_r;
    tz2_r   <= tz1_r;

    rot_r[0] <= round_q60(cycp2_r);
    rot_r[1] <= round_q60(a01_r - sycr2_r);
    rot_r[2] <= round_q60(sysr2_r + a02_r);
    rot_r[3] <= round_q60(sycp2_r);
    rot_r[4] <= round_q60(cycr2_r + a11_r);
    rot_r[5] <= round_q60(a12_r - cysr2_r);
    rot_r[6] <= round_q60(-(q60_t'(sp2_r) <<< 30));
    rot_r[7] <= round_q60(cpsr2_r);
    rot_r[8] <= round_q60(cpcr2_r);
    tx3_r    <= tx2_r;
    ty3_r    <= ty2_r;
    tz3_r    <= tz2_r;
  end

  assign valid_o = v3_r;
  assign rot_o   = rot_r;
  assign tx_o    = tx3_r;
  assign ty_o    = ty3_r;
  assign tz_o    = tz3_r;

endmodule

// File: design/euler_pose_to_transform.sv
// ----------------------------------------------------------------------------
// euler_pose_to_transform
// Z-Y-X Euler pose (translation, roll, pitch, yaw) to a 3x4 rigid transform.
// ----------------------------------------------------------------------------
// Input channel: drive in_* and raise start; a transaction is taken at each
// clock edge with start high and busy low. busy is always low, so one pose
// can enter every cycle.
// Result channel: out_valid is high for exactly one cycle per transaction,
// with rot_00..rot_22 (signed Q1.14, rounded) and trans_x/y/z (pass-through)
// on the out_* ports in that cycle. The receiver cannot stall; results must
// be captured when out_valid is high.
// Pipeline: out_valid comes from the last of 35 register stages (the first
// loaded at the accepting edge: fold, 30 CORDIC steps and a clamp stage
// for the three angles in parallel, then three product/sum stages).
// Throughput: one transaction per cycle, set by the fully pipelined CORDIC
// and multiplier stages.
// Reset: synchronous, active low; clears all valid bits, so no result
// emerges from data in flight before reset.
// ----------------------------------------------------------------------------
module euler_pose_to_transform (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [eupt_pkg::POS_W-1:0]      in_pos_x,
  input  logic signed [eupt_pkg::POS_W-1:0]      in_pos_y,
  input  logic signed [eupt_pkg::POS_W-1:0]      in_pos_z,
  input  logic signed [eupt_pkg::ANGLE_BITS-1:0] in_roll_angle,
  input  logic signed [eupt_pkg::ANGLE_BITS-1:0] in_pitch_angle,
  input  logic signed [eupt_pkg::ANGLE_BITS-1:0] in_yaw_angle,
  output logic                                  out_valid,
  output logic signed [eupt_pkg::ROT_W-1:0]      out_rot_00,
  output logic signed [eupt_pkg::ROT_W-1:0]      out_rot_01,
  output logic signed [eupt_pkg::ROT_W-1:0]      out_rot_02,
  output logic signed [eupt_pkg::ROT_W-1:0]      out_rot_10,
  output logic signed [eupt_pkg::ROT_W-1:0]      out_rot_11,
  output logic signed [eupt_pkg::ROT_W-1:0]      out_rot_12,
  output logic signed [eupt_pkg::ROT_W-1:0]      out_rot_20,
  output logic signed [eupt_pkg::ROT_W-1:0]      out_rot_21,
  output logic signed [eupt_pkg::ROT_W-1:0]      out_rot_22,
  output logic signed [eupt_pkg::POS_W-1:0]      out_trans_x,
  output logic signed [eupt_pkg::POS_W-1:0]      out_trans_y,
  output logic signed [eupt_pkg::POS_W-1:0]      out_trans_z
);
  import eupt_pkg::*;

  logic  vld_r [0:CORDIC_LAT-1];
  pos_t  tx_r  [0:CORDIC_LAT-1];
  pos_t  ty_r  [0:CORDIC_LAT-1];
  pos_t  tz_r  [0:CORDIC_LAT-1];
  q30_t  cr, sr, cp, sp, cy, sy;
  rot_t  rot [0:8];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CORDIC_LAT; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= start & ~busy;
      for (int i = 1; i < CORDIC_LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    tx_r[0] <= in_pos_x;
    ty_r[0] <= in_pos_y;
    tz_r[0] <= in_pos_z;
    for (int i = 1; i < CORDIC_LAT; i++) begin
      tx_r[i] <= tx_r[i-1];
      ty_r[i] <= ty_r[i-1];
      tz_r[i] <= tz_r[i-1];
    end
  end

  eupt_cordic u_roll  (.clk(clk), .angle_i(in_roll_angle),  .cos_o(cr), .sin_o(sr));
  eupt_cordic u_pitch (.clk(clk), .angle_i(in_pitch_angle), .cos_o(cp), .sin_o(sp));
  eupt_cordic u_yaw   (.clk(clk), .angle_i(in_yaw_angle),   .cos_o(cy), .sin_o(sy));

  eupt_matrix u_matrix (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (vld_r[CORDIC_LAT-1]),
    .cr_i    (cr),
    .sr_i    (sr),
    .cp_i    (cp),
    .sp_i    (sp),
    .cy_i    (cy),
    .sy_i    (sy),
    .tx_i    (tx_r[CORDIC_LAT-1]),
    .ty_i    (ty_r[CORDIC_LAT-1]),
    .tz_i    (tz_r[CORDIC_LAT-1]),
    .valid_o (out_valid),
    .rot_o   (rot),
    .tx_o    (out_trans_x),
    .ty_o    (out_trans_y),
    .tz_o    (out_trans_z)
  );

  assign out_rot_00 = rot[0];
  assign out_rot_01 = rot[1];
  assign out_rot_02 = rot[2];
  assign out_rot_10 = rot[3];
  assign out_rot_11 = rot[4];
  assign out_rot_12 = rot[5];
  assign out_rot_20 = rot[6];
  assign out_rot_21 = rot[7];
  assign out_rot_22 = rot[8];

endmodule

// File: test/pose_transform_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_transform_checker
// Watches the pose input and transform result channels, computes the
// expected rotation matrix and translation for each accepted pose, and
// compares every result field by field in order of arrival.
// ----------------------------------------------------------------------------
module pose_transform_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic                                  busy,
  input  logic signed [eupt_pkg::POS_W-1:0]      in_pos_x,
  input  logic signed [eupt_pkg::POS_W-1:0]      in_pos_y,
  input  logic signed [eupt_pkg::POS_W-1:0]      in_pos_z,
  input  logic signed [eupt_pkg::ANGLE_BITS-1:0] in_roll_angle,
  input  logic signed [eupt_pkg::ANGLE_BITS-1:0] in_pitch_angle,
  input  logic signed [eupt_pkg::ANGLE_BITS-1:0] in_yaw_angle,
  input  logic                                  out_valid,
  input  logic signed [eupt_pkg::ROT_W-1:0]      out_rot [9],
  input  logic signed [eupt_pkg::POS_W-1:0]      out_trans_x,
  input  logic signed [eupt_pkg::POS_W-1:0]      out_trans_y,
  input  logic signed [eupt_pkg::POS_W-1:0]      out_trans_z,
  output int                                    fail_count,
  output int                                    pending
);
  import eupt_pkg::*;

  typedef struct {
    logic signed [ROT_W-1:0] rot [9];
    logic signed [POS_W-1:0] tx, ty, tz;
  } transform_t;

  transform_t transform_q[$];

  localparam longint GAIN = 64'sd652032874;
  localparam longint UNIT = 64'sd1073741824;

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void angle_sincos(input logic [ANGLE_BITS-1:0] ang,
                                       output longint c, output longint s);
    logic [31:0] a;
    logic        flip;
    longint      x, y, z, dx, dy;
    a = {ang, {(32 - ANGLE_BITS){1'b0}}};
    flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
    if (flip) a = a + 32'h8000_0000;
    z = longint'($signed(a));
    x = GAIN;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end
    end
    x = clip(x, UNIT);
    y = clip(y, UNIT);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint q30_product(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic logic signed [ROT_W-1:0] q60_to_entry(longint v);
    longint r;
    r = (v + (64'sd1 <<< (60 - ROT_FRAC_BITS - 1))) >>> (60 - ROT_FRAC_BITS);
    r = clip(r, 64'sd1 <<< ROT_FRAC_BITS);
    return r[ROT_W-1:0];
  endfunction

  function automatic transform_t pose_to_transform(
      logic [ANGLE_BITS-1:0] r, p, w, logic signed [POS_W-1:0] px, py, pz);
    transform_t t;
    longint cr, sr, cp, sp, cy, sy, cysp, sysp;
    angle_sincos(r, cr, sr);
    angle_sincos(p, cp, sp);
    angle_sincos(w, cy, sy);
    cysp = q30_product(cy, sp);
    sysp = q30_product(sy, sp);
    t.rot[0] = q60_to_entry(cy * cp);
    t.rot[1] = q60_to_entry(cysp * sr - sy * cr);
    t.rot[2] = q60_to_entry(sy * sr + cysp * cr);
    t.rot[3] = q60_to_entry(sy * cp);
    t.rot[4] = q60_to_entry(cy * cr + sysp * sr);
    t.rot[5] = q60_to_entry(sysp * cr - cy * sr);
    t.rot[6] = q60_to_entry(-sp * UNIT);
    t.rot[7] = q60_to_entry(cp * sr);
    t.rot[8] = q60_to_entry(cp * cr);
    t.tx = px;
    t.ty = py;
    t.tz = pz;
    return t;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("checker: mismatch %s got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = transform_q.size();

  always @(posedge clk) begin
    transform_t e;
    if (rst_n && start && !busy)
      transform_q.push_back(pose_to_transform(in_roll_angle, in_pitch_angle,
                                              in_yaw_angle, in_pos_x, in_pos_y,
                                              in_pos_z));
    if (rst_n && out_valid) begin
      if (transform_q.size() == 0) begin
        report_mismatch("unexpected transaction", 0, 0);
      end else begin
        e = transform_q.pop_front();
        for (int k = 0; k < 9; k++)
          if (out_rot[k] !== e.rot[k])
            report_mismatch($sformatf("rot_%0d%0d", k / 3, k % 3), out_rot[k], e.rot[k]);
        if (out_trans_x !== e.tx) report_mismatch("trans_x", out_trans_x, e.tx);
        if (out_trans_y !== e.ty) report_mismatch("trans_y", out_trans_y, e.ty);
        if (out_trans_z !== e.tz) report_mismatch("trans_z", out_trans_z, e.tz);
      end
    end
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives poses into the Euler pose to transform block: directed angle and
// translation extremes, then random poses under several idling phases.
// ----------------------------------------------------------------------------
module tb_top;
  import eupt_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [POS_W-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [ANGLE_BITS-1:0] in_roll_angle = '0, in_pitch_angle = '0, in_yaw_angle = '0;
  logic out_valid;
  logic signed [ROT_W-1:0] out_rot [9];
  logic signed [POS_W-1:0] out_trans_x, out_trans_y, out_trans_z;
  int fail_count, pending;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  euler_pose_to_transform dut (
    .clk, .rst_n, .start, .busy,
    .in_pos_x, .in_pos_y, .in_pos_z, .in_roll_angle, .in_pitch_angle, .in_yaw_angle,
    .out_valid,
    .out_rot_00(out_rot[0]), .out_rot_01(out_rot[1]), .out_rot_02(out_rot[2]),
    .out_rot_10(out_rot[3]), .out_rot_11(out_rot[4]), .out_rot_12(out_rot[5]),
    .out_rot_20(out_rot[6]), .out_rot_21(out_rot[7]), .out_rot_22(out_rot[8]),
    .out_trans_x, .out_trans_y, .out_trans_z
  );

  pose_transform_checker checker_i (.*);

  int idle_pct;

  task automatic send_pose(logic [31:0] px, py, pz, logic [15:0] r, p, w);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_pos_x <= px; in_pos_y <= py; in_pos_z <= pz;
    in_roll_angle <= r; in_pitch_angle <= p; in_yaw_angle <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(4))
      0: return 16'(16'h4000 * $urandom_range(3) + $urandom_range(2) - 1);
      1: return 16'($urandom_range(8) * 16'h1000);
      default: return 16'($urandom);
    endcase
  endfunction

  localparam logic [15:0] DIRECTED_ANGLES [10] = '{
    16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF,
    16'h3FFF, 16'h4001, 16'hBFFF, 16'hC001, 16'h2000};

  initial begin
    idle_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_pose(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'h0, 16'h0, 16'h0);
    send_pose(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 16'hFFFF, 16'h8000, 16'h7FFF);
    foreach (DIRECTED_ANGLES[i])
      send_pose($urandom, $urandom, $urandom, DIRECTED_ANGLES[i],
                DIRECTED_ANGLES[(i + 3) % 10], DIRECTED_ANGLES[(i + 7) % 10]);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 49 : (ph == 2) ? 11 : 0;
      for (int n = 0; n < 100; n++)
        send_pose($urandom, $urandom, $urandom, pick_angle(), pick_angle(), pick_angle());
    end
    start <= 1'b0;
    while (pending > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// File: euler_pose_to_transform.f
design/eupt_pkg.sv
design/eupt_cordic.sv
design/eupt_matrix.sv
design/euler_pose_to_transform.sv
test/pose_transform_checker.sv
test/tb_top.sv
